// ----- rtl/heightmap_vertex_normals_defines.svh -----
// ----------------------------------------------------------------------------
// heightmap vertex normals assertion macros
// shared concurrent assertion forms on i_clk, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMALS_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMALS_DEFINES_SVH

// same-cycle implication
`define HVN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HVN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hvn_pkg.sv -----
// ----------------------------------------------------------------------------
// hvn_pkg
// constants, widths and register codes of the heightmap vertex normal block
// ----------------------------------------------------------------------------
package hvn_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 512;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;

    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 10;
    localparam int STEP_W   = 24;
    localparam int HGT_W    = 8;
    localparam int OUT_W    = 16;

    // normalizer datapath widths
    localparam int MAG_W    = 56;
    localparam int NM_W     = 30;
    localparam int PROD_W   = 2 * NM_W;
    localparam int SQ_W     = 62;
    localparam int RT_W     = 63;
    localparam int N_W      = 31;
    localparam int Q_W      = 31;
    localparam int NUM_W    = 62;
    localparam int ACC_W    = 34;
    localparam int FRAC_W   = 22;
    localparam int K_FACE   = 30;
    localparam int K_OUT    = 14;

    typedef enum logic [1:0] {
        CFG_GRID_COLS,
        CFG_GRID_ROWS,
        CFG_X_STEP,
        CFG_Y_STEP
    } t_cfg_idx;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // address offset of neighbor k of the 3x3 window, row major from (-1,-1)
    function automatic logic [ADDR_W-1:0] nbr_offset(input logic [3:0] k);
        logic [ADDR_W-1:0] off;
        case (k)
            4'd0:    off = ADDR_W'(-MAX_COLS - 1);
            4'd1:    off = ADDR_W'(-MAX_COLS);
            4'd2:    off = ADDR_W'(-MAX_COLS + 1);
            4'd3:    off = ADDR_W'(-1);
            4'd5:    off = ADDR_W'(1);
            4'd6:    off = ADDR_W'(MAX_COLS - 1);
            4'd7:    off = ADDR_W'(MAX_COLS);
            4'd8:    off = ADDR_W'(MAX_COLS + 1);
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

// ----- rtl/heightmap_vertex_normals.sv -----
// ----------------------------------------------------------------------------
// heightmap vertex normals
// height grid store with smoothed unit vertex normal queries
// ----------------------------------------------------------------------------
// usage
//   request channel: i_start with i_operation, i_row, i_col, i_height_value,
//   taken at a clock edge where i_start is high and o_busy is low
//   write requests store one byte and finish in the cycle they are taken
//   query requests read the 3x3 neighborhood, build up to six face normals and
//   normalize their sum; one result strobes on o_valid for exactly one cycle
//   query timing is set by the shared normalizer, used once per enabled face
//   and once for the sum, each time after its alignment shifts; skipped faces
//   bypass it (one bit per cycle square root, one bit per cycle divider)
//   queries outside the grid answer zero through the S_ZERO state
//   throughput: one query at a time, o_busy high until the result strobe
//   reset: a clearing pass writes 255 to all 524288 store entries, one entry per
//   cycle, with o_busy high; config writes are taken throughout
//   the receiver cannot stall: o_valid is high for one cycle only, o_normal_* hold until the next result
//   config: i_cfg_we writes register i_cfg_addr at once, no read-back
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normals_defines.svh"

module heightmap_vertex_normals
    import hvn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_operation,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [COL_W-1:0]        i_col,
    input  logic [HGT_W-1:0]        i_height_value,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [STEP_W-1:0]       i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ZERO, S_READ, S_MULXY, S_FSEL, S_FM0, S_FM1,
        S_NSHIFT, S_NSQ, S_NSQRT, S_NDIV_LD, S_NDIV, S_NEXT
    } t_state;

    t_state                  r_state;

    // config registers
    logic [COLS_W-1:0]       r_grid_cols;
    logic [ROWS_W-1:0]       r_grid_rows;
    logic [STEP_W-1:0]       r_x_step;
    logic [STEP_W-1:0]       r_y_step;

    // height store
    logic [HGT_W-1:0]        r_mem [2**ADDR_W];
    logic [HGT_W-1:0]        r_mem_q;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [HGT_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;

    // query context
    logic [ADDR_W-1:0]       r_center;
    logic [HGT_W-1:0]        r_h [9];
    logic [5:0]              r_face_en;
    logic [2:0]              r_face;
    logic                    r_final;
    logic [4:0]              r_cnt;
    logic [1:0]              r_comp;
    logic [2*STEP_W-1:0]     r_xy;

    // normalizer state
    logic [MAG_W-1:0]        r_m [3];
    logic                    r_neg [3];
    logic [PROD_W-1:0]       r_prod;
    logic [SQ_W-1:0]         r_s;
    logic [RT_W-1:0]         r_res;
    logic [NUM_W-1:0]        r_num;
    logic [N_W:0]            r_rem;
    logic [Q_W-1:0]          r_q;
    logic signed [ACC_W-1:0] r_u [3];
    logic signed [ACC_W-1:0] r_acc [3];

    // result registers
    logic                    r_valid;
    logic signed [OUT_W-1:0] r_nx;
    logic signed [OUT_W-1:0] r_ny;
    logic signed [OUT_W-1:0] r_nz;

    // effective grid size and query checks
    logic [COLS_W-1:0]       cols_eff;
    logic [ROWS_W-1:0]       rows_eff;
    logic                    in_grid;
    logic                    row_next_ok;
    logic                    col_next_ok;
    logic                    has_up;
    logic                    has_left;
    logic                    accept;

    // face difference terms
    logic [3:0]              face_base;
    logic                    face_b;
    logic [HGT_W-1:0]        h00, h01, h10, h11;
    logic signed [HGT_W:0]   d0, d1;
    logic [HGT_W-1:0]        d0_abs, d1_abs;

    // shared multiplier
    logic [NM_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;

    // normalizer combinational terms
    logic [MAG_W-1:0]        big;
    logic [RT_W-1:0]         sq_bit;
    logic [RT_W-1:0]         sq_try;
    logic [N_W-1:0]          nrm_n;
    logic [NUM_W-1:0]        div_num;
    logic [N_W+1:0]          div_t;
    logic [N_W+1:0]          div_d;
    logic                    div_ge;
    logic [Q_W-1:0]          div_q;
    logic signed [ACC_W-1:0] div_u;
    logic [MAG_W-1:0]        acc_mag [3];
    logic [NM_W-1:0]         m_sel;

    assign cols_eff    = (r_grid_cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : r_grid_cols;
    assign rows_eff    = (r_grid_rows > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : r_grid_rows;
    assign in_grid     = (ROWS_W'(i_row) < rows_eff) && (COLS_W'(i_col) < cols_eff);
    assign row_next_ok = (ROWS_W'(i_row) + ROWS_W'(1)) < rows_eff;
    assign col_next_ok = (COLS_W'(i_col) + COLS_W'(1)) < cols_eff;
    assign has_up      = (i_row != '0);
    assign has_left    = (i_col != '0);
    assign accept      = i_start && (r_state == S_IDLE);

    // store ports: clearing pass, request writes, neighbor reads
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {i_row, i_col};
        mem_wdata = i_height_value;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '1;
        end else if (accept && (i_operation == OP_WRITE)) begin
            mem_we    = 1'b1;
        end
        mem_raddr = r_center + nbr_offset(r_cnt[3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    // corner heights of the current face's cell in the 3x3 window
    always_comb begin
        case (r_face)
            3'd0:    begin face_base = 4'd4; face_b = 1'b0; end
            3'd1:    begin face_base = 4'd4; face_b = 1'b1; end
            3'd2:    begin face_base = 4'd3; face_b = 1'b0; end
            3'd3:    begin face_base = 4'd0; face_b = 1'b0; end
            3'd4:    begin face_base = 4'd0; face_b = 1'b1; end
            3'd5:    begin face_base = 4'd1; face_b = 1'b1; end
            default: begin face_base = 4'd4; face_b = 1'b0; end
        endcase
        h00 = r_h[face_base];
        h01 = r_h[face_base + 4'd1];
        h10 = r_h[face_base + 4'd3];
        h11 = r_h[face_base + 4'd4];
        if (face_b) begin
            d0 = $signed({1'b0, h10}) - $signed({1'b0, h11});
            d1 = $signed({1'b0, h10}) - $signed({1'b0, h00});
        end else begin
            d0 = $signed({1'b0, h00}) - $signed({1'b0, h01});
            d1 = $signed({1'b0, h11}) - $signed({1'b0, h01});
        end
        d0_abs = d0[HGT_W] ? HGT_W'(-d0) : d0[HGT_W-1:0];
        d1_abs = d1[HGT_W] ? HGT_W'(-d1) : d1[HGT_W-1:0];
    end

    // shared multiplier operand select
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    m_sel = r_m[0][NM_W-1:0];
            2'd1:    m_sel = r_m[1][NM_W-1:0];
            2'd2:    m_sel = r_m[2][NM_W-1:0];
            default: m_sel = '0;
        endcase
        case (r_state)
            S_MULXY: begin mul_a = NM_W'(r_x_step); mul_b = NM_W'(r_y_step); end
            S_FM0:   begin mul_a = NM_W'(d0_abs);   mul_b = NM_W'(r_y_step); end
            S_FM1:   begin mul_a = NM_W'(d1_abs);   mul_b = NM_W'(r_x_step); end
            S_NSQ:   begin mul_a = m_sel;           mul_b = m_sel;           end
            default: begin mul_a = '0;              mul_b = '0;              end
        endcase
        mul_p = mul_a * mul_b;
    end

    // normalizer terms
    always_comb begin
        big = r_m[0];
        if (r_m[1] > big) big = r_m[1];
        if (r_m[2] > big) big = r_m[2];
        sq_bit  = RT_W'(1) << (6'd62 - {r_cnt, 1'b0});
        sq_try  = r_res + sq_bit;
        nrm_n   = r_res[N_W-1:0];
        if (r_final) begin
            div_num = (NUM_W'(r_m[r_comp][NM_W-1:0]) << (K_OUT + 1)) + NUM_W'(nrm_n);
        end else begin
            div_num = (NUM_W'(r_m[r_comp][NM_W-1:0]) << (K_FACE + 1)) + NUM_W'(nrm_n);
        end
        // partial remainder may reach twice the divisor after the shift
        div_t   = {r_rem, r_num[6'd30 - {1'b0, r_cnt}]};
        div_d   = {1'b0, nrm_n, 1'b0};
        div_ge  = (div_t >= div_d);
        div_q   = {r_q[Q_W-2:0], div_ge};
        div_u   = r_neg[r_comp] ? -$signed(ACC_W'(div_q)) : $signed(ACC_W'(div_q));
        for (int i = 0; i < 3; i++) begin
            acc_mag[i] = r_acc[i][ACC_W-1] ? MAG_W'(-r_acc[i]) : MAG_W'(r_acc[i]);
        end
    end

    // sequencer, datapath and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_valid     <= 1'b0;
            r_grid_cols <= COLS_W'(640);
            r_grid_rows <= ROWS_W'(480);
            r_x_step    <= STEP_W'(13128);
            r_y_step    <= STEP_W'(17513);
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_data[COLS_W-1:0];
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[ROWS_W-1:0];
                    CFG_X_STEP:    r_x_step    <= i_cfg_data;
                    CFG_Y_STEP:    r_y_step    <= i_cfg_data;
                    default:       ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept && (i_operation == OP_QUERY)) begin
                        r_center     <= {i_row, i_col};
                        r_cnt        <= '0;
                        r_face       <= '0;
                        r_face_en[0] <= row_next_ok && col_next_ok;
                        r_face_en[1] <= row_next_ok && col_next_ok;
                        r_face_en[2] <= has_left && row_next_ok;
                        r_face_en[3] <= has_up && has_left;
                        r_face_en[4] <= has_up && has_left;
                        r_face_en[5] <= has_up && col_next_ok;
                        for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                        r_state      <= in_grid ? S_READ : S_ZERO;
                    end
                end
                S_ZERO: begin
                    r_nx    <= '0;
                    r_ny    <= '0;
                    r_nz    <= '0;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    // read data arrives in the cycle after its address
                    if (r_cnt != '0) r_h[r_cnt[3:0] - 4'd1] <= r_mem_q;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd9) r_state <= S_MULXY;
                end
                S_MULXY: begin
                    r_xy    <= mul_p[2*STEP_W-1:0];
                    r_state <= S_FSEL;
                end
                S_FSEL: begin
                    if (r_face == 3'd6) begin
                        // all faces summed: normalize the sum
                        for (int i = 0; i < 3; i++) begin
                            r_m[i]   <= acc_mag[i];
                            r_neg[i] <= r_acc[i][ACC_W-1];
                        end
                        r_final <= 1'b1;
                        r_state <= S_NSHIFT;
                    end else if (!r_face_en[r_face]) begin
                        r_face <= r_face + 3'd1;
                    end else begin
                        r_state <= S_FM0;
                    end
                end
                S_FM0: begin
                    r_m[0]   <= MAG_W'(mul_p) << FRAC_W;
                    r_neg[0] <= d0[HGT_W];
                    r_state  <= S_FM1;
                end
                S_FM1: begin
                    r_m[1]   <= MAG_W'(mul_p) << FRAC_W;
                    r_neg[1] <= d1[HGT_W];
                    // z term is -255 * x * y
                    r_m[2]   <= (MAG_W'(r_xy) << 8) - MAG_W'(r_xy);
                    r_neg[2] <= 1'b1;
                    r_final  <= 1'b0;
                    r_state  <= S_NSHIFT;
                end
                S_NSHIFT: begin
                    if (big == '0) begin
                        for (int i = 0; i < 3; i++) r_u[i] <= '0;
                        r_state <= S_NEXT;
                    end else if (big >= (MAG_W'(1) << 38)) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 8;
                    end else if (big >= (MAG_W'(1) << 30)) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (big < (MAG_W'(1) << 21)) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 8;
                    end else if (big < (MAG_W'(1) << 29)) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_s     <= '0;
                        r_state <= S_NSQ;
                    end
                end
                S_NSQ: begin
                    // square registered in r_prod, summed in the next cycle
                    r_prod <= mul_p;
                    if (r_cnt != '0) r_s <= r_s + SQ_W'(r_prod);
                    if (r_cnt == 5'd3) begin
                        r_cnt   <= '0;
                        r_res   <= '0;
                        r_state <= S_NSQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_NSQRT: begin
                    if (RT_W'(r_s) >= sq_try) begin
                        r_s   <= SQ_W'(RT_W'(r_s) - sq_try);
                        r_res <= (r_res >> 1) + sq_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_comp  <= '0;
                        r_state <= S_NDIV_LD;
                    end
                end
                S_NDIV_LD: begin
                    r_num   <= div_num;
                    r_rem   <= (N_W+1)'(div_num[NUM_W-1:Q_W]);
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_NDIV;
                end
                S_NDIV: begin
                    r_rem <= (N_W+1)'(div_ge ? (div_t - div_d) : div_t);
                    r_q   <= div_q;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_u[r_comp] <= div_u;
                        if (r_comp == 2'd2) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_NDIV_LD;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_final) begin
                        r_nx    <= r_u[0][OUT_W-1:0];
                        r_ny    <= r_u[1][OUT_W-1:0];
                        r_nz    <= r_u[2][OUT_W-1:0];
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        for (int i = 0; i < 3; i++) r_acc[i] <= r_acc[i] + r_u[i];
                        r_face  <= r_face + 3'd1;
                        r_state <= S_FSEL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_normal_x = r_nx;
    assign o_normal_y = r_ny;
    assign o_normal_z = r_nz;

    // a result strobe always ends a busy stretch
    `HVN_ASSERT_SAME(a_valid_after_busy, o_valid, $past(o_busy), "result without a query")
    // a taken query keeps the block busy
    `HVN_ASSERT_NEXT(a_query_busy, accept && (i_operation == OP_QUERY), o_busy,
        "query not started")
    // a write never produces a result
    `HVN_ASSERT_NEXT(a_write_silent, accept && (i_operation == OP_WRITE), !o_valid,
        "result after a write")

endmodule
